/* rtl/core/rosat_pkg.sv */
package rosat_pkg;

	// Default coordinate width (Q12.4)
	localparam int COORD_BITS_DEF = 16;

	// Corners per rectangle, axes per test, lanes (one per corner of both rectangles)
	localparam int NUM_CORNERS = 4;
	localparam int NUM_AXES    = 4;
	localparam int NUM_LANES   = 2 * NUM_CORNERS;
	localparam int AXIS_BITS   = $clog2(NUM_AXES);

	typedef logic [AXIS_BITS-1:0] axis_idx_t;

	// Axis order of the test
	localparam axis_idx_t AXIS_A_TOP   = 2'd0;
	localparam axis_idx_t AXIS_A_RIGHT = 2'd1;
	localparam axis_idx_t AXIS_B_LEFT  = 2'd2;
	localparam axis_idx_t AXIS_B_TOP   = 2'd3;

	// Corner slots inside a rectangle
	localparam int CORNER_UR = 0;
	localparam int CORNER_UL = 1;
	localparam int CORNER_LR = 2;
	localparam int CORNER_LL = 3;

	// Tag that travels with each axis through the lanes
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} ctl_t;

	// Verdict from the merging stage
	typedef struct packed {
		logic done;
		logic colliding;
	} res_t;

endpackage

/* rtl/core/rosat_in_if.sv */
interface rosat_in_if #(
	parameter int CoordBits = rosat_pkg::COORD_BITS_DEF
) ();
	logic                        valid;
	logic                        ready;
	logic                        second_rect;
	logic signed [CoordBits-1:0] upper_right_x;
	logic signed [CoordBits-1:0] upper_right_y;
	logic signed [CoordBits-1:0] upper_left_x;
	logic signed [CoordBits-1:0] upper_left_y;
	logic signed [CoordBits-1:0] lower_right_x;
	logic signed [CoordBits-1:0] lower_right_y;
	logic signed [CoordBits-1:0] lower_left_x;
	logic signed [CoordBits-1:0] lower_left_y;
	logic signed [CoordBits-1:0] body_x;
	logic signed [CoordBits-1:0] body_y;

	modport source (
		output valid, second_rect, upper_right_x, upper_right_y, upper_left_x, upper_left_y,
		       lower_right_x, lower_right_y, lower_left_x, lower_left_y, body_x, body_y,
		input  ready
	);

	modport sink (
		input  valid, second_rect, upper_right_x, upper_right_y, upper_left_x, upper_left_y,
		       lower_right_x, lower_right_y, lower_left_x, lower_left_y, body_x, body_y,
		output ready
	);
endinterface

/* rtl/core/rosat_out_if.sv */
interface rosat_out_if ();
	logic valid;
	logic ready;
	logic colliding;

	modport source (output valid, colliding, input ready);
	modport sink (input valid, colliding, output ready);
endinterface

/* rtl/core/rect_overlap_sat_core.sv */
// Throughput: one A beat per cycle while idle; a B beat blocks new beats until its
//   verdict reaches the output register, as the four axes step through the eight
//   corner lanes one axis per cycle and the merge drains.
// Reset: arst_n clears the sequencer, the pipeline tags and the output valid at once;
//   the stored A rectangle is undefined until the first A beat.
module rect_overlap_sat_core #(
	parameter int COORD_BITS = rosat_pkg::COORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	rosat_in_if.sink       rect,
	rosat_out_if.source    result
);
	localparam int CornerBits = COORD_BITS + 1;
	localparam int AxisBits   = COORD_BITS + 2;
	localparam int DotBits    = 2 * COORD_BITS + 4;
	localparam int Corners    = rosat_pkg::NUM_CORNERS;
	localparam rosat_pkg::axis_idx_t LastAxis = rosat_pkg::axis_idx_t'(rosat_pkg::NUM_AXES - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	state_t                       state_q;
	rosat_pkg::axis_idx_t         axis_q;
	logic signed [CornerBits-1:0] a_x_q [Corners];
	logic signed [CornerBits-1:0] a_y_q [Corners];
	logic signed [CornerBits-1:0] b_x_q [Corners];
	logic signed [CornerBits-1:0] b_y_q [Corners];
	logic signed [CornerBits-1:0] in_x [Corners];
	logic signed [CornerBits-1:0] in_y [Corners];
	logic signed [AxisBits-1:0]   axis_x;
	logic signed [AxisBits-1:0]   axis_y;
	logic signed [AxisBits-1:0]   axis_x_s1;
	logic signed [AxisBits-1:0]   axis_y_s1;
	rosat_pkg::ctl_t              ctl_s1;
	rosat_pkg::ctl_t              ctl_s2;
	rosat_pkg::ctl_t              ctl_s3;
	logic signed [DotBits-1:0]    dot_s3 [rosat_pkg::NUM_LANES];
	rosat_pkg::res_t              res;
	logic                         accept;
	logic                         out_free;
	logic                         out_load;
	logic                         out_load_col;
	logic                         hold_col_q;
	logic                         out_valid_q;
	logic                         out_col_q;

	assign accept   = rect.valid & rect.ready;
	assign out_free = !out_valid_q | result.ready;

	// Load the output register from the merge or from the held verdict
	assign out_load     = out_free & (((state_q == ST_DRAIN) & res.done) | (state_q == ST_HOLD));
	assign out_load_col = (state_q == ST_HOLD) ? hold_col_q : res.colliding;

	// Absolute corners of the incoming rectangle
	always_comb begin
		in_x[rosat_pkg::CORNER_UR] = CornerBits'(rect.upper_right_x) + CornerBits'(rect.body_x);
		in_y[rosat_pkg::CORNER_UR] = CornerBits'(rect.upper_right_y) + CornerBits'(rect.body_y);
		in_x[rosat_pkg::CORNER_UL] = CornerBits'(rect.upper_left_x) + CornerBits'(rect.body_x);
		in_y[rosat_pkg::CORNER_UL] = CornerBits'(rect.upper_left_y) + CornerBits'(rect.body_y);
		in_x[rosat_pkg::CORNER_LR] = CornerBits'(rect.lower_right_x) + CornerBits'(rect.body_x);
		in_y[rosat_pkg::CORNER_LR] = CornerBits'(rect.lower_right_y) + CornerBits'(rect.body_y);
		in_x[rosat_pkg::CORNER_LL] = CornerBits'(rect.lower_left_x) + CornerBits'(rect.body_x);
		in_y[rosat_pkg::CORNER_LL] = CornerBits'(rect.lower_left_y) + CornerBits'(rect.body_y);
	end

	// Store the corners of A or B
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < Corners; k++) begin
				if (rect.second_rect) begin
					b_x_q[k] <= in_x[k];
					b_y_q[k] <= in_y[k];
				end else begin
					a_x_q[k] <= in_x[k];
					a_y_q[k] <= in_y[k];
				end
			end
		end
	end

	// Form the current axis from edge corners
	always_comb begin
		unique case (axis_q)
			rosat_pkg::AXIS_A_TOP: begin
				axis_x = AxisBits'(a_x_q[rosat_pkg::CORNER_UR]) - AxisBits'(a_x_q[rosat_pkg::CORNER_UL]);
				axis_y = AxisBits'(a_y_q[rosat_pkg::CORNER_UR]) - AxisBits'(a_y_q[rosat_pkg::CORNER_UL]);
			end
			rosat_pkg::AXIS_A_RIGHT: begin
				axis_x = AxisBits'(a_x_q[rosat_pkg::CORNER_UR]) - AxisBits'(a_x_q[rosat_pkg::CORNER_LR]);
				axis_y = AxisBits'(a_y_q[rosat_pkg::CORNER_UR]) - AxisBits'(a_y_q[rosat_pkg::CORNER_LR]);
			end
			rosat_pkg::AXIS_B_LEFT: begin
				axis_x = AxisBits'(b_x_q[rosat_pkg::CORNER_UL]) - AxisBits'(b_x_q[rosat_pkg::CORNER_LL]);
				axis_y = AxisBits'(b_y_q[rosat_pkg::CORNER_UL]) - AxisBits'(b_y_q[rosat_pkg::CORNER_LL]);
			end
			rosat_pkg::AXIS_B_TOP: begin
				axis_x = AxisBits'(b_x_q[rosat_pkg::CORNER_UL]) - AxisBits'(b_x_q[rosat_pkg::CORNER_UR]);
				axis_y = AxisBits'(b_y_q[rosat_pkg::CORNER_UL]) - AxisBits'(b_y_q[rosat_pkg::CORNER_UR]);
			end
			default: begin
				axis_x = '0;
				axis_y = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		axis_x_s1 <= axis_x;
		axis_y_s1 <= axis_y;
	end

	// Tag each axis and carry the tag past the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1.valid <= (state_q == ST_RUN);
			ctl_s1.first <= (axis_q == rosat_pkg::AXIS_A_TOP);
			ctl_s1.last  <= (axis_q == LastAxis);
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
		end
	end

	// Eight lanes: A corners then B corners
	for (genvar g = 0; g < rosat_pkg::NUM_LANES; g++) begin : g_lane
		logic signed [CornerBits-1:0] cx;
		logic signed [CornerBits-1:0] cy;

		if (g < Corners) begin : g_a
			assign cx = a_x_q[g];
			assign cy = a_y_q[g];
		end else begin : g_b
			assign cx = b_x_q[g-Corners];
			assign cy = b_y_q[g-Corners];
		end

		rosat_lane #(.CoordBits(COORD_BITS)) u_lane (
			.clk      (clk),
			.corner_x (cx),
			.corner_y (cy),
			.axis_x   (axis_x_s1),
			.axis_y   (axis_y_s1),
			.dot      (dot_s3[g])
		);
	end

	rosat_merge #(.CoordBits(COORD_BITS)) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s3 (ctl_s3),
		.dot_s3 (dot_s3),
		.res    (res)
	);

	// Sequence the axes, wait for the verdict, hand it to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= rosat_pkg::AXIS_A_TOP;
			out_valid_q <= 1'b0;
			out_col_q   <= 1'b0;
			hold_col_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_col_q   <= out_load_col;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && rect.second_rect) begin
						state_q <= ST_RUN;
						axis_q  <= rosat_pkg::AXIS_A_TOP;
					end
				end
				ST_RUN: begin
					axis_q <= axis_q + 1'b1;
					if (axis_q == LastAxis) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (res.done) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							hold_col_q <= res.colliding;
							state_q    <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rect.ready       = (state_q == ST_IDLE);
	assign result.valid     = out_valid_q;
	assign result.colliding = out_col_q;

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (state_q == ST_DRAIN))
		else $error("verdict arrived outside drain");

	a_run_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && axis_q == LastAxis) |=> (state_q == ST_DRAIN))
		else $error("axis sweep did not end in drain");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!ctl_s1.valid && !ctl_s3.valid))
		else $error("beat accepted while lanes busy");

	a_first_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.valid && ctl_s1.first) |-> $past(accept, 2))
		else $error("axis sweep started without a B beat");
endmodule

/* rtl/core/rosat_lane.sv */
module rosat_lane #(
	parameter int CoordBits = rosat_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic signed [CoordBits:0]     corner_x,
	input  logic signed [CoordBits:0]     corner_y,
	input  logic signed [CoordBits+1:0]   axis_x,
	input  logic signed [CoordBits+1:0]   axis_y,
	output logic signed [2*CoordBits+3:0] dot
);
	localparam int ProdBits = 2 * CoordBits + 3;
	localparam int DotBits  = ProdBits + 1;

	logic signed [ProdBits-1:0] prod_x;
	logic signed [ProdBits-1:0] prod_y;
	logic signed [ProdBits-1:0] prod_x_s2;
	logic signed [ProdBits-1:0] prod_y_s2;
	logic signed [DotBits-1:0]  dot_s3;

	// Project the corner on the axis, one multiplier per component
	assign prod_x = ProdBits'(corner_x) * ProdBits'(axis_x);
	assign prod_y = ProdBits'(corner_y) * ProdBits'(axis_y);

	always_ff @(posedge clk) begin
		prod_x_s2 <= prod_x;
		prod_y_s2 <= prod_y;
	end

	// Sum the two components at full width
	always_ff @(posedge clk) begin
		dot_s3 <= DotBits'(prod_x_s2) + DotBits'(prod_y_s2);
	end

	assign dot = dot_s3;
endmodule

/* rtl/core/rosat_merge.sv */
module rosat_merge #(
	parameter int CoordBits = rosat_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rosat_pkg::ctl_t               ctl_s3,
	input  logic signed [2*CoordBits+3:0] dot_s3 [rosat_pkg::NUM_LANES],
	output rosat_pkg::res_t               res
);
	localparam int DotBits = 2 * CoordBits + 4;
	localparam int Pairs   = rosat_pkg::NUM_CORNERS / 2;

	function automatic logic signed [DotBits-1:0] smin(
		input logic signed [DotBits-1:0] a,
		input logic signed [DotBits-1:0] b
	);
		return (a <= b) ? a : b;
	endfunction

	function automatic logic signed [DotBits-1:0] smax(
		input logic signed [DotBits-1:0] a,
		input logic signed [DotBits-1:0] b
	);
		return (a <= b) ? b : a;
	endfunction

	rosat_pkg::ctl_t           ctl_s4;
	rosat_pkg::ctl_t           ctl_s5;
	logic signed [DotBits-1:0] a_lo_s4 [Pairs];
	logic signed [DotBits-1:0] a_hi_s4 [Pairs];
	logic signed [DotBits-1:0] b_lo_s4 [Pairs];
	logic signed [DotBits-1:0] b_hi_s4 [Pairs];
	logic signed [DotBits-1:0] a_lo_s5;
	logic signed [DotBits-1:0] a_hi_s5;
	logic signed [DotBits-1:0] b_lo_s5;
	logic signed [DotBits-1:0] b_hi_s5;
	logic                      gap;
	logic                      sep_any;
	logic                      sep_q;
	rosat_pkg::res_t           res_s6;

	// First level: bounds of corner pairs
	always_ff @(posedge clk) begin
		for (int p = 0; p < Pairs; p++) begin
			a_lo_s4[p] <= smin(dot_s3[2*p], dot_s3[2*p+1]);
			a_hi_s4[p] <= smax(dot_s3[2*p], dot_s3[2*p+1]);
			b_lo_s4[p] <= smin(dot_s3[rosat_pkg::NUM_CORNERS+2*p],
			                   dot_s3[rosat_pkg::NUM_CORNERS+2*p+1]);
			b_hi_s4[p] <= smax(dot_s3[rosat_pkg::NUM_CORNERS+2*p],
			                   dot_s3[rosat_pkg::NUM_CORNERS+2*p+1]);
		end
	end

	// Second level: full interval of each rectangle
	always_ff @(posedge clk) begin
		a_lo_s5 <= smin(a_lo_s4[0], a_lo_s4[1]);
		a_hi_s5 <= smax(a_hi_s4[0], a_hi_s4[1]);
		b_lo_s5 <= smin(b_lo_s4[0], b_lo_s4[1]);
		b_hi_s5 <= smax(b_hi_s4[0], b_hi_s4[1]);
	end

	// Advance the axis tag alongside the bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// Touching intervals overlap; a gap on any axis separates the rectangles
	assign gap     = !((b_lo_s5 <= a_hi_s5) && (a_lo_s5 <= b_hi_s5));
	assign sep_any = gap | (sep_q & !ctl_s5.first);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q  <= 1'b0;
			res_s6 <= '0;
		end else begin
			res_s6.done <= ctl_s5.valid & ctl_s5.last;
			if (ctl_s5.valid) begin
				sep_q            <= sep_any;
				res_s6.colliding <= !sep_any;
			end
		end
	end

	assign res = res_s6;
endmodule
